/* rtl/mcmp_pkg.sv */
`default_nettype none

package mcmp_pkg;

  // parser phase
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_t;

  // held command
  typedef enum logic [1:0] {
    CMD_ON   = 2'd0,
    CMD_OFF  = 2'd1,
    CMD_CTL  = 2'd2,
    CMD_BEND = 2'd3
  } cmd_t;

  // event kinds on the output
  localparam logic [1:0] KIND_NOTE  = 2'd0;
  localparam logic [1:0] KIND_CTRL  = 2'd1;
  localparam logic [1:0] KIND_PITCH = 2'd2;

  // upper nibble of the status bytes that start a message
  localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
  localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
  localparam logic [3:0] STAT_CTRL     = 4'hB;
  localparam logic [3:0] STAT_BEND     = 4'hE;

  // controllers 32..63 share these top bits
  localparam logic [2:0] CTRL_PAIR_HI = 3'b001;

  // configuration register indexes
  localparam logic [1:0] REG_IGNORE_PAIRS = 2'd0;
  localparam logic [1:0] REG_CONFIG_MODE  = 2'd1;

  localparam int TDATA_W = 32;

  typedef struct packed {
    logic        valid;
    logic [1:0]  event_kind;
    logic [3:0]  channel;
    logic [7:0]  number;
    logic [15:0] value;
    logic        for_configure;
  } evt_t;

endpackage

`default_nettype wire

/* rtl/midi_channel_message_parser_core.sv */
// an event appears on m_tvalid in the cycle after its second data byte is taken
// throughput: one byte per cycle; s_tready drops only while an event waits and m_tready is low
// one output register holds the event, so input and output stall on each other for one stage
// reset: synchronous active-high rst returns the parser to waiting for a status byte,
//   clears the held command, channel and first data byte, both config bits and m_tvalid
`default_nettype none

module midi_channel_message_parser_core (
  input  wire         clk,
  input  wire         rst,
  // input stream
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] midi_byte
  // event stream
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // [1:0] event_kind, [5:2] channel, [13:6] number,
                                 // [29:14] value, [30] for_configure, [31] zero
  // configuration
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [0:0]  cfg_wdata
);

  logic           ignore_ctrl_pairs;
  logic           configure_mode;
  logic           accept;
  logic           space;
  mcmp_pkg::evt_t evt;

  // configuration registers; indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_ctrl_pairs <= 1'b0;
      configure_mode    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        mcmp_pkg::REG_IGNORE_PAIRS: ignore_ctrl_pairs <= cfg_wdata[0];
        mcmp_pkg::REG_CONFIG_MODE:  configure_mode    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // a byte is taken whenever the output stage can hold its possible event
  assign s_tready = space;
  assign accept   = s_tvalid && s_tready;

  // parser state and event building
  mcmp_decode u_decode (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .midi_byte         (s_tdata),
    .ignore_ctrl_pairs (ignore_ctrl_pairs),
    .configure_mode    (configure_mode),
    .evt               (evt)
  );

  // output register
  mcmp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .evt      (evt),
    .space    (space),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // pitch events never carry a number
  a_pitch_number_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] == mcmp_pkg::KIND_PITCH) |-> (m_tdata[13:6] == 8'd0))
    else $error("pitch event with nonzero number");

  // note events carry only a pressed flag
  a_note_flag: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] == mcmp_pkg::KIND_NOTE) |-> (m_tdata[29:15] == 15'd0))
    else $error("note event value wider than a flag");

  // a stalled event keeps its contents
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("event changed while stalled");

endmodule

`default_nettype wire

/* rtl/mcmp_decode.sv */
`default_nettype none

module mcmp_decode (
  input  wire              clk,
  input  wire              rst,
  input  wire              accept,
  input  wire [7:0]        midi_byte,
  input  wire              ignore_ctrl_pairs,
  input  wire              configure_mode,
  output mcmp_pkg::evt_t   evt
);

  mcmp_pkg::phase_t phase, phase_next;
  mcmp_pkg::cmd_t   cmd, cmd_next;
  logic [3:0]       chan, chan_next;
  logic [7:0]       first, first_next;
  logic             pair_drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= mcmp_pkg::PH_IDLE;
      cmd   <= mcmp_pkg::CMD_ON;
      chan  <= 4'd0;
      first <= 8'd0;
    end else begin
      phase <= phase_next;
      cmd   <= cmd_next;
      chan  <= chan_next;
      first <= first_next;
    end
  end

  // next state
  always_comb begin
    phase_next = phase;
    cmd_next   = cmd;
    chan_next  = chan;
    first_next = first;
    if (accept) begin
      case (phase)
        mcmp_pkg::PH_FIRST: begin
          first_next = midi_byte;
          phase_next = mcmp_pkg::PH_SECOND;
        end
        mcmp_pkg::PH_SECOND: begin
          phase_next = mcmp_pkg::PH_IDLE;
        end
        default: begin
          phase_next = mcmp_pkg::PH_IDLE;
          case (midi_byte[7:4])
            mcmp_pkg::STAT_NOTE_OFF: begin
              cmd_next   = mcmp_pkg::CMD_OFF;
              chan_next  = midi_byte[3:0];
              phase_next = mcmp_pkg::PH_FIRST;
            end
            mcmp_pkg::STAT_NOTE_ON: begin
              cmd_next   = mcmp_pkg::CMD_ON;
              chan_next  = midi_byte[3:0];
              phase_next = mcmp_pkg::PH_FIRST;
            end
            mcmp_pkg::STAT_CTRL: begin
              cmd_next   = mcmp_pkg::CMD_CTL;
              chan_next  = midi_byte[3:0];
              phase_next = mcmp_pkg::PH_FIRST;
            end
            mcmp_pkg::STAT_BEND: begin
              cmd_next   = mcmp_pkg::CMD_BEND;
              chan_next  = midi_byte[3:0];
              phase_next = mcmp_pkg::PH_FIRST;
            end
            default: begin
              phase_next = mcmp_pkg::PH_IDLE;
            end
          endcase
        end
      endcase
    end
  end

  assign pair_drop = ignore_ctrl_pairs && (first[7:5] == mcmp_pkg::CTRL_PAIR_HI);

  // event built from the second data byte
  always_comb begin
    evt.valid         = 1'b0;
    evt.event_kind    = mcmp_pkg::KIND_NOTE;
    evt.channel       = chan;
    evt.number        = first;
    evt.value         = 16'd0;
    evt.for_configure = configure_mode;
    if (accept && phase == mcmp_pkg::PH_SECOND) begin
      case (cmd)
        mcmp_pkg::CMD_ON: begin
          evt.valid = 1'b1;
          evt.value = {15'd0, (midi_byte != 8'd0)};
        end
        mcmp_pkg::CMD_OFF: begin
          evt.valid = 1'b1;
        end
        mcmp_pkg::CMD_CTL: begin
          evt.valid      = !pair_drop;
          evt.event_kind = mcmp_pkg::KIND_CTRL;
          evt.value      = {8'd0, midi_byte};
        end
        default: begin
          evt.valid      = 1'b1;
          evt.event_kind = mcmp_pkg::KIND_PITCH;
          evt.number     = 8'd0;
          evt.value      = {1'b0, midi_byte, 7'd0} + {8'd0, first};
        end
      endcase
    end
  end

  a_evt_only_second: assert property (@(posedge clk) disable iff (rst)
    evt.valid |-> (accept && phase == mcmp_pkg::PH_SECOND))
    else $error("event outside second data byte");

  a_second_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == mcmp_pkg::PH_SECOND) |=> (phase == mcmp_pkg::PH_IDLE))
    else $error("parser did not return to idle");

  a_first_then_second: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == mcmp_pkg::PH_FIRST) |=>
      (phase == mcmp_pkg::PH_SECOND && first == $past(midi_byte)))
    else $error("first data byte not held");

endmodule

`default_nettype wire

/* rtl/mcmp_out_reg.sv */
`default_nettype none

module mcmp_out_reg (
  input  wire                              clk,
  input  wire                              rst,
  input  mcmp_pkg::evt_t                   evt,
  output logic                             space,
  output logic                             m_tvalid,
  input  wire                              m_tready,
  output logic [mcmp_pkg::TDATA_W-1:0]     m_tdata
);

  logic [mcmp_pkg::TDATA_W-1:0] data;

  // room for a new item when empty or when the held one leaves this cycle
  assign space = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (evt.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.valid) begin
      data <= {1'b0, evt.for_configure, evt.value, evt.number, evt.channel, evt.event_kind};
    end
  end

  assign m_tdata = data;

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    evt.valid |=> m_tvalid)
    else $error("loaded item not shown");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    evt.valid |-> space)
    else $error("held item overwritten");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[mcmp_pkg::TDATA_W-1] == 1'b0))
    else $error("padding bit set");

endmodule

`default_nettype wire

/* sim/testbench.sv */
`default_nettype none

module testbench;

  // spare register indexes, writes there must leave both bits alone
  localparam logic [1:0] REG_SPARE_LO = 2'd2;
  localparam logic [1:0] REG_SPARE_HI = 2'd3;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_BYTES    = 305;
  localparam int NUM_PHASES     = 6;
  localparam int CALM_PHASE     = 4;
  localparam int PRINT_CAP      = 40;

  // one event word as it sits on m_tdata, lowest field last
  typedef struct packed {
    logic        pad;
    logic        for_cfg;
    logic [15:0] value;
    logic [7:0]  number;
    logic [3:0]  channel;
    logic [1:0]  kind;
  } event_word_t;

  class event_scoreboard;
    mcmp_pkg::phase_t phase;
    mcmp_pkg::cmd_t   cmd;
    logic [3:0]       chan;
    logic [7:0]       first;
    logic             ignore_pairs;
    logic             cfg_mode;
    event_word_t      expected_events[$];
    int               errors;
    int               checked;
    int               filtered;

    function new();
      phase        = mcmp_pkg::PH_IDLE;
      cmd          = mcmp_pkg::CMD_ON;
      chan         = 4'd0;
      first        = 8'd0;
      ignore_pairs = 1'b0;
      cfg_mode     = 1'b0;
      errors       = 0;
      checked      = 0;
      filtered     = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic val);
      case (idx)
        mcmp_pkg::REG_IGNORE_PAIRS: ignore_pairs = val;
        mcmp_pkg::REG_CONFIG_MODE:  cfg_mode = val;
        default: ;
      endcase
    endfunction

    function void push_event(logic [1:0] kind, logic [7:0] num, logic [15:0] val);
      event_word_t ev;
      ev.pad     = 1'b0;
      ev.for_cfg = cfg_mode;
      ev.value   = val;
      ev.number  = num;
      ev.channel = chan;
      ev.kind    = kind;
      expected_events.push_back(ev);
    endfunction

    // advance the parser by one accepted byte
    function void note_byte(logic [7:0] b);
      case (phase)
        mcmp_pkg::PH_FIRST: begin
          first = b;
          phase = mcmp_pkg::PH_SECOND;
        end
        mcmp_pkg::PH_SECOND: begin
          case (cmd)
            mcmp_pkg::CMD_ON:  push_event(mcmp_pkg::KIND_NOTE, first, {15'd0, b != 8'd0});
            mcmp_pkg::CMD_OFF: push_event(mcmp_pkg::KIND_NOTE, first, 16'd0);
            mcmp_pkg::CMD_CTL: begin
              if (!ignore_pairs || first[7:5] != mcmp_pkg::CTRL_PAIR_HI)
                push_event(mcmp_pkg::KIND_CTRL, first, {8'd0, b});
              else
                filtered++;
            end
            default: push_event(mcmp_pkg::KIND_PITCH, 8'd0, {8'd0, first} + {1'b0, b, 7'd0});
          endcase
          phase = mcmp_pkg::PH_IDLE;
        end
        default: begin
          // waiting for status, anything else is skipped
          phase = mcmp_pkg::PH_FIRST;
          case (b[7:4])
            mcmp_pkg::STAT_NOTE_OFF: cmd = mcmp_pkg::CMD_OFF;
            mcmp_pkg::STAT_NOTE_ON:  cmd = mcmp_pkg::CMD_ON;
            mcmp_pkg::STAT_CTRL:     cmd = mcmp_pkg::CMD_CTL;
            mcmp_pkg::STAT_BEND:     cmd = mcmp_pkg::CMD_BEND;
            default:                 phase = mcmp_pkg::PH_IDLE;
          endcase
          if (phase == mcmp_pkg::PH_FIRST) chan = b[3:0];
        end
      endcase
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      if (errors < PRINT_CAP)
        $display("mismatch on %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    task check_event(event_word_t got);
      event_word_t want;
      if (expected_events.size() == 0) begin
        report("unexpected event", got, 32'd0);
      end else begin
        want = expected_events.pop_front();
        checked++;
        if (got.kind !== want.kind)
          report("event_kind", 32'(got.kind), 32'(want.kind));
        if (got.channel !== want.channel)
          report("channel", 32'(got.channel), 32'(want.channel));
        if (got.number !== want.number)
          report("number", 32'(got.number), 32'(want.number));
        if (got.value !== want.value)
          report("value", 32'(got.value), 32'(want.value));
        if (got.for_cfg !== want.for_cfg)
          report("for_configure", 32'(got.for_cfg), 32'(want.for_cfg));
        if (got.pad !== want.pad)
          report("tdata pad bit", 32'(got.pad), 32'(want.pad));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [0:0]  cfg_wdata;

  event_scoreboard sb = new();

  int gap_pct = 20;
  int phase_bytes;
  int total_bytes;
  int idle_cycles;
  int settings_run;

  logic [7:0] basic_seq[$] = '{8'h90, 8'h3C, 8'h64,   // note on, pressed
                               8'h9F, 8'h7F, 8'h00,   // note on with zero velocity
                               8'h80, 8'h00, 8'h7F,   // note off
                               8'hEF, 8'hFF, 8'hFF,   // pitch bend, data with bit 7 set
                               8'hF8, 8'hC3};         // skipped while idle
  logic [7:0] pair_seq[$]  = '{8'hB5, 8'h1F, 8'h01,   // controllers around the pair window
                               8'hB5, 8'h20, 8'h02,
                               8'hB5, 8'h3F, 8'h03,
                               8'hB5, 8'h40, 8'h04};

  bit ign_set[NUM_PHASES]  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
  bit mode_set[NUM_PHASES] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

  midi_channel_message_parser_core uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // event sink: check on handshake, then pick the next ready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_event(m_tdata);
    m_tready <= ($urandom_range(99) >= gap_pct);
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [7:0] random_data();
    if ($urandom_range(7) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(127));
  endfunction

  task send_byte(input logic [7:0] b);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_byte(b);
    phase_bytes++;
    total_bytes++;
  endtask

  // mostly whole messages, some cut short, some raw noise
  task send_random_unit();
    logic [3:0] nib;
    logic [3:0] chan;
    logic [7:0] d1;
    logic [7:0] d2;
    int         pick;
    pick = $urandom_range(99);
    if (pick >= 80) begin
      send_byte(8'($urandom_range(255)));
    end else begin
      chan = 4'($urandom_range(15));
      case ($urandom_range(3))
        0: nib = mcmp_pkg::STAT_NOTE_OFF;
        1: nib = mcmp_pkg::STAT_NOTE_ON;
        2: nib = mcmp_pkg::STAT_CTRL;
        default: nib = mcmp_pkg::STAT_BEND;
      endcase
      d1 = random_data();
      d2 = random_data();
      if (nib == mcmp_pkg::STAT_CTRL && $urandom_range(1) == 1) d1 = 8'($urandom_range(71, 24));
      if (nib == mcmp_pkg::STAT_NOTE_ON && $urandom_range(3) == 0) d2 = 8'd0;
      send_byte({nib, chan});
      send_byte(d1);
      // a short message lets the next unit's first byte land as second data
      if (pick < 72) send_byte(d2);
    end
  endtask

  // wait for every expected event, then wait on a little longer for a dropped one
  task drain();
    while (sb.expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task apply_config(input bit ign, input bit mode);
    logic [1:0] spare;
    logic       junk;
    spare = ($urandom_range(1) == 1) ? REG_SPARE_HI : REG_SPARE_LO;
    junk  = 1'($urandom_range(1));
    cfg_we    <= 1'b1;
    cfg_index <= mcmp_pkg::REG_IGNORE_PAIRS;
    cfg_wdata <= ign;
    @(posedge clk);
    sb.write_reg(mcmp_pkg::REG_IGNORE_PAIRS, ign);
    cfg_index <= mcmp_pkg::REG_CONFIG_MODE;
    cfg_wdata <= mode;
    @(posedge clk);
    sb.write_reg(mcmp_pkg::REG_CONFIG_MODE, mode);
    cfg_index <= spare;
    cfg_wdata <= junk;
    @(posedge clk);
    sb.write_reg(spare, junk);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = 8'd0;
    m_tready    = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = mcmp_pkg::REG_IGNORE_PAIRS;
    cfg_wdata   = 1'b0;
    idle_cycles = 0;
    total_bytes = 0;
    settings_run = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      phase_bytes = 0;
      if (p > 0) begin
        drain();
        apply_config(ign_set[p], mode_set[p]);
      end
      gap_pct = (p == CALM_PHASE) ? 0 : 20;
      if (p == 0) foreach (basic_seq[i]) send_byte(basic_seq[i]);
      if (p == 1) foreach (pair_seq[i]) send_byte(pair_seq[i]);
      while (phase_bytes < PHASE_BYTES) send_random_unit();
      s_tvalid <= 1'b0;
      @(posedge clk);
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.expected_events.size() != 0)
      sb.report("events never seen", sb.expected_events.size(), 32'd0);

    $display("sent %0d midi bytes over %0d register settings, checked %0d events",
             total_bytes, settings_run, sb.checked);
    $display("%0d control changes were dropped by the pair filter", sb.filtered);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/mcmp_pkg.sv
rtl/mcmp_decode.sv
rtl/mcmp_out_reg.sv
rtl/midi_channel_message_parser_core.sv
sim/testbench.sv
